// ===== design/isle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isle_pkg
// Shared types and constants for the indexed sequence list engine.
// ----------------------------------------------------------------------------
package isle_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W      = 32;

    typedef enum logic [2:0] {
        ACT_APPEND     = 3'd0,
        ACT_PREPEND    = 3'd1,
        ACT_INSERT     = 3'd2,
        ACT_REMOVE     = 3'd3,
        ACT_REMOVE_FRONT = 3'd4,
        ACT_REMOVE_END = 3'd5,
        ACT_FIND       = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_OOB   = 3'd1,
        ST_EMPTY = 3'd2,
        ST_FULL  = 3'd3,
        ST_NONE  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SH_NONE  = 2'd0,
        SH_OPEN  = 2'd1,
        SH_CLOSE = 2'd2
    } t_shift;

    // broadcast to every cell of the row
    typedef struct packed {
        t_shift              shift;
        logic [IDX_W-1:0]    pos;
        logic [DATA_W-1:0]   value;
    } t_cell_cmd;

endpackage : isle_pkg
`default_nettype wire

// ===== design/isle_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isle_cell
// One list slot: holds an entry, shifts to/from its neighbors, compares.
// ----------------------------------------------------------------------------
module isle_cell
    import isle_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [IDX_W-1:0]  i_index,
    input  wire logic [CNT_W-1:0]  i_count,
    input  wire logic              i_en,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic [DATA_W-1:0] i_left,
    input  wire logic [DATA_W-1:0] i_right,
    input  wire logic              i_hit,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_hit,
    output logic                   o_first
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_match;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.shift)
            SH_OPEN: begin
                if (i_index > i_cmd.pos) begin
                    n_data = i_left;
                end else if (i_index == i_cmd.pos) begin
                    n_data = i_cmd.value;
                end
            end
            SH_CLOSE: begin
                if (i_index >= i_cmd.pos) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    // only slots below the count take part in a search
    assign w_match = (CNT_W'(i_index) < i_count) && (r_data == i_cmd.value);
    assign o_first = w_match && !i_hit;
    assign o_hit   = w_match || i_hit;
    assign o_data  = r_data;

endmodule : isle_cell
`default_nettype wire

// ===== design/indexed_sequence_list_engine_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_sequence_list_engine_top
// Ordered list of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel  dir  bits  contents (low bit first)
//  s_axis   in   40    action[2:0] value[34:3] position_in[39:35]
//  m_axis   out  16    status[2:0] position_out[6:3] entry_count[11:7] pad
//
//  One transaction per cycle while m_axis is not stalling: the whole cell row
//  shifts or compares in the cycle the command is taken, the result lands in
//  the output register. m_axis_tvalid rises in the cycle after accept.
//  s_axis_tready is high while the output register is empty or being drained.
//  Reset empties the list; entry contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_sequence_list_engine_top
    import isle_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // action, value, position_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // status, position_out, entry_count
);

    logic                  w_accept;
    logic [2:0]            w_action;
    logic [DATA_W-1:0]     w_value;
    logic [4:0]            w_pos_in;
    logic [31:0]           w_pos_ext;
    logic [31:0]           w_cnt_ext;
    logic                  w_full;
    logic                  w_empty;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    t_cell_cmd             w_cmd;
    t_status               w_status;

    logic [DATA_W-1:0]     w_data  [MAX_ENTRIES];
    logic [MAX_ENTRIES:0]  w_hit;
    logic [MAX_ENTRIES-1:0] w_first;
    logic [IDX_W-1:0]      w_found;

    logic                  r_out_valid;
    logic [2:0]            r_status;
    logic [3:0]            r_position;
    logic [4:0]            r_entry_count;

    assign w_action  = s_axis_tdata[2:0];
    assign w_value   = s_axis_tdata[34:3];
    assign w_pos_in  = s_axis_tdata[39:35];
    assign w_pos_ext = 32'(w_pos_in);
    assign w_cnt_ext = 32'(r_count);
    assign w_full    = (r_count == CNT_W'(MAX_ENTRIES));
    assign w_empty   = (r_count == '0);

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_cmd.shift = SH_NONE;
        w_cmd.pos   = '0;
        w_cmd.value = w_value;
        w_status    = ST_OK;
        n_count     = r_count;
        unique case (w_action)
            ACT_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.shift = SH_OPEN;
                    w_cmd.pos   = IDX_W'(r_count);
                    n_count     = r_count + 1'b1;
                end
            end
            ACT_PREPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.shift = SH_OPEN;
                    n_count     = r_count + 1'b1;
                end
            end
            ACT_INSERT: begin
                if (w_pos_ext > w_cnt_ext) begin
                    w_status = ST_OOB;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.shift = SH_OPEN;
                    w_cmd.pos   = IDX_W'(w_pos_in);
                    n_count     = r_count + 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (w_pos_ext >= w_cnt_ext) begin
                    w_status = ST_OOB;
                end else begin
                    w_cmd.shift = SH_CLOSE;
                    w_cmd.pos   = IDX_W'(w_pos_in);
                    n_count     = r_count - 1'b1;
                end
            end
            ACT_REMOVE_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_cmd.shift = SH_CLOSE;
                    n_count     = r_count - 1'b1;
                end
            end
            ACT_REMOVE_END: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            ACT_FIND: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_hit[MAX_ENTRIES]) begin
                    w_status = ST_OK;
                end else begin
                    w_status = ST_NONE;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // hit flag ripples from the front so only the first match is flagged
    assign w_hit[0] = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (g == 0) begin : g_front
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_back
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        isle_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_count (r_count),
            .i_en    (w_accept),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_hit   (w_hit[g]),
            .o_data  (w_data[g]),
            .o_hit   (w_hit[g+1]),
            .o_first (w_first[g])
        );
    end

    always_comb begin
        w_found = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_found = w_found | (w_first[i] ? IDX_W'(i) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= w_status;
            r_position    <= (w_action == ACT_FIND && w_status == ST_OK) ? 4'(w_found) : 4'd0;
            r_entry_count <= 5'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_entry_count, r_position, r_status};

endmodule : indexed_sequence_list_engine_top
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed sequence list engine.
// Drives list actions on s_axis and keeps a shadow copy of the list to
// predict each result. Every m_axis transaction is checked field by field
// against the oldest prediction. Both sides idle at random outside one streaming stretch.
// ----------------------------------------------------------------------------
module tb;
    import isle_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT  = 2000;

    typedef struct {
        logic [2:0] status;
        logic [3:0] position;
        logic [4:0] count;
    } t_list_result;

    // Shadow copy of the list; predicts the result of every accepted action.
    class list_scoreboard;
        logic [DATA_W-1:0] slots [MAX_ENTRIES];
        int unsigned       fill;
        t_list_result      expected_results [$];
        int unsigned       mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function void open_gap(int unsigned at, logic [DATA_W-1:0] val);
            for (int unsigned i = fill; i > at; i--) slots[i] = slots[i-1];
            slots[at] = val;
            fill++;
        endfunction

        function void close_gap(int unsigned at);
            for (int unsigned i = at; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
        endfunction

        function void apply_action(logic [2:0] act, logic [DATA_W-1:0] val,
                                   logic [4:0] idx);
            t_list_result r;
            r.status   = ST_OK;
            r.position = '0;
            case (act)
                ACT_APPEND: begin
                    if (fill >= MAX_ENTRIES) r.status = ST_FULL;
                    else open_gap(fill, val);
                end
                ACT_PREPEND: begin
                    if (fill >= MAX_ENTRIES) r.status = ST_FULL;
                    else open_gap(0, val);
                end
                ACT_INSERT: begin
                    // bounds win over fullness
                    if (idx > fill) r.status = ST_OOB;
                    else if (fill >= MAX_ENTRIES) r.status = ST_FULL;
                    else open_gap(idx, val);
                end
                ACT_REMOVE: begin
                    if (idx >= fill) r.status = ST_OOB;
                    else close_gap(idx);
                end
                ACT_REMOVE_FRONT: begin
                    if (fill == 0) r.status = ST_EMPTY;
                    else close_gap(0);
                end
                ACT_REMOVE_END: begin
                    if (fill == 0) r.status = ST_EMPTY;
                    else fill--;
                end
                ACT_FIND: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.status = ST_NONE;
                        for (int unsigned i = 0; i < fill; i++) begin
                            if (r.status == ST_NONE && slots[i] == val) begin
                                r.status   = ST_OK;
                                r.position = i[3:0];
                            end
                        end
                    end
                end
                default: ;  // code seven does nothing
            endcase
            r.count = fill[4:0];
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [15:0] word);
            t_list_result e;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, word);
                mismatches++;
                return;
            end
            e = expected_results.pop_front();
            if (word[2:0] !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, word[2:0]);
                mismatches++;
            end
            if (word[6:3] !== e.position) begin
                $display("%0t: position expected %0d actual %0d",
                         $time, e.position, word[6:3]);
                mismatches++;
            end
            if (word[11:7] !== e.count) begin
                $display("%0t: count expected %0d actual %0d", $time, e.count, word[11:7]);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [39:0] s_axis_tdata  = '0;  // action, value, position_in
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;        // status, position_out, entry_count, pad

    logic        tx_gaps = 1'b1;
    logic        rx_gaps = 1'b1;
    int unsigned stall_cycles = 0;

    list_scoreboard shadow = new();

    indexed_sequence_list_engine_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (rx_gaps) m_axis_tready <= ($urandom_range(99) >= 34);
        else m_axis_tready <= 1'b1;
    end

    // transaction monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                shadow.apply_action(s_axis_tdata[2:0], s_axis_tdata[34:3],
                                    s_axis_tdata[39:35]);
            if (m_axis_tvalid && m_axis_tready)
                shadow.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send(input logic [2:0] act, input logic [DATA_W-1:0] val,
                        input logic [4:0] idx);
        while (tx_gaps && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, val, act};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold off until every outstanding result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (shadow.expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            4, 5: return $urandom_range(9);  // small pool so finds hit
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [2:0]        act;
        logic [DATA_W-1:0] val;
        logic [4:0]        idx;
        int unsigned       r, grow_w, shrink_w;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty-list, bounds and find corner cases
        send(ACT_FIND,         32'd5,        5'd0);
        send(ACT_REMOVE_FRONT, 32'd0,        5'd0);
        send(ACT_REMOVE_END,   32'd0,        5'd0);
        send(ACT_REMOVE,       32'd0,        5'd0);
        send(ACT_INSERT,       32'd1,        5'd1);
        send(ACT_INSERT,       32'h8000_0000, 5'd0);
        send(ACT_APPEND,       32'h7FFF_FFFF, 5'd31);
        send(ACT_PREPEND,      32'h0,        5'd0);
        send(ACT_INSERT,       32'd7,        5'd31);
        send(ACT_INSERT,       32'hFFFF_FFFF, 5'd3);
        send(ACT_FIND,         32'hFFFF_FFFF, 5'd0);
        send(ACT_FIND,         32'd12345,    5'd0);
        send(ACT_REMOVE,       32'd0,        5'd31);
        send(ACT_REMOVE,       32'd0,        5'd4);
        send(ACT_REMOVE,       32'd0,        5'd1);
        send(3'd7,             32'hFFFF_FFFF, 5'd31);
        send(ACT_REMOVE_END,   32'd0,        5'd0);
        send(ACT_REMOVE_FRONT, 32'd0,        5'd0);
        // fill up with duplicates, then hit the full cases
        for (int i = 0; i < MAX_ENTRIES; i++) send(ACT_APPEND, i % 5, 5'd0);
        send(ACT_APPEND,  32'd9,  5'd0);
        send(ACT_PREPEND, 32'd9,  5'd0);
        send(ACT_INSERT,  32'd9,  5'd16);
        send(ACT_INSERT,  32'd9,  5'd17);
        send(ACT_FIND,    32'd3,  5'd0);
        send(ACT_REMOVE,  32'd0,  5'd15);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // long stretch with both sides streaming flat out
            tx_gaps = !(n >= 400 && n < 550);
            rx_gaps = tx_gaps;
            if (n == 400) drain();
            case ((n / 100) % 4)
                0: begin grow_w = 70; shrink_w = 15; end
                1: begin grow_w = 40; shrink_w = 35; end
                2: begin grow_w = 15; shrink_w = 70; end
                default: begin grow_w = 35; shrink_w = 30; end
            endcase
            r   = $urandom_range(99);
            idx = 5'($urandom_range(shadow.fill + 1));
            val = pick_value();
            if (r < 8) begin
                act = 3'($urandom_range(7));
                idx = 5'($urandom_range(31));
                val = $urandom;
            end else if (r < 8 + grow_w) begin
                act = 3'($urandom_range(ACT_INSERT, ACT_APPEND));
            end else if (r < 8 + grow_w + shrink_w) begin
                act = 3'($urandom_range(ACT_REMOVE_END, ACT_REMOVE));
            end else begin
                act = ACT_FIND;
                if (shadow.fill > 0 && $urandom_range(1))
                    val = shadow.slots[$urandom_range(shadow.fill - 1)];
            end
            send(act, val, idx);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (shadow.expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (shadow.mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

// ===== indexed_sequence_list_engine_top.f =====
design/isle_pkg.sv
design/isle_cell.sv
design/indexed_sequence_list_engine_top.sv
verif/tb.sv
